// ===== rtl/core/float_exp_negative_lut2048_defines.svh =====
// Assertion macros shared by the checker of the negative-range exponential block.
`ifndef FLOAT_EXP_NEGATIVE_LUT2048_DEFINES_SVH
`define FLOAT_EXP_NEGATIVE_LUT2048_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define FEXP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that also checks during reset.
`define FEXP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fexp_pkg.sv =====
// Package with constants, the scale table and helper functions of the exponential block.
`timescale 1ns / 1ps
package fexp_pkg;

    // Table geometry and pipeline depth.
    localparam int unsigned RomDepth = 2048;
    localparam int unsigned IdxW     = 11;
    localparam int unsigned NumStg   = 29;

    // Single-precision constants as raw bits.
    localparam logic [31:0] MAGIC_BIAS     = 32'h45C00000;
    localparam logic [31:0] NEG_MAGIC_BIAS = 32'hC5C00000;
    localparam logic [31:0] LOG2E          = 32'h3FB8AA3B;
    localparam logic [31:0] NEG_LN2_HI     = 32'hBF300000;
    localparam logic [31:0] NEG_LN2_LO     = 32'hBBB90BFC;
    localparam logic [31:0] COEF_C1        = 32'h3F7FFFFF;
    localparam logic [30:0] CUTOFF_MAG     = 31'h42AEAC4F;
    localparam logic [31:0] QNAN_CANON     = 32'h7FC00000;
    localparam logic [31:0] QUIET_BIT      = 32'h00400000;

    typedef logic [31:0] t_rom [RomDepth];

    // Leading zero count of a 48-bit word; an all-zero word gives 48.
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                cnt = 6'(47 - i);
            end
        end
        return cnt;
    endfunction

    // True when the bits encode a NaN.
    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Product of two Q2.62 values, truncated to Q2.62.
    function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Square root of a Q2.62 value, truncated to Q2.62.
    function automatic logic [63:0] sqrtq62(input logic [63:0] v);
        logic [127:0] tgt;
        logic [127:0] sq;
        logic [63:0]  r;
        logic [63:0]  c;
        tgt = {64'd0, v} << 62;
        r   = 64'd0;
        for (int b = 62; b >= 0; b--) begin
            c  = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= tgt) begin
                r = c;
            end
        end
        return r;
    endfunction

    // Builds the scale table: bits of 2^(k/2048) minus k shifted left by 12.
    function automatic t_rom build_rom();
        t_rom            tbl;
        logic [63:0]     root [IdxW];
        logic [63:0]     p;
        logic [63:0]     m;
        logic [31:0]     w;
        logic [IdxW-1:0] kb;
        root[IdxW-1] = sqrtq62(64'h8000000000000000);
        for (int j = IdxW - 1; j > 0; j--) begin
            root[j-1] = sqrtq62(root[j]);
        end
        for (int k = 0; k < RomDepth; k++) begin
            kb = IdxW'(k);
            p  = 64'h4000000000000000;
            for (int j = 0; j < IdxW; j++) begin
                if (kb[j]) begin
                    p = mulq62(p, root[j]);
                end
            end
            m      = (p + (64'd1 << 38)) >> 39;
            w      = m[31:0] + 32'h3F000000;
            tbl[k] = w - 32'({kb, 12'd0});
        end
        return tbl;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

endpackage

// ===== rtl/core/fexp_in_if.sv =====
// Input channel interface: one word carries x and its last flag.
`timescale 1ns / 1ps
interface fexp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_bits;
    logic        last_in;

    modport source (output valid, output x_bits, output last_in, input ready);
    modport sink (input valid, input x_bits, input last_in, output ready);
endinterface

// ===== rtl/core/fexp_out_if.sv =====
// Output channel interface: one word carries exp(x) and its last flag.
`timescale 1ns / 1ps
interface fexp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] f_bits;
    logic        last_out;

    modport source (output valid, output f_bits, output last_out, input ready);
    modport sink (input valid, input f_bits, input last_out, output ready);
endinterface

// ===== rtl/core/fexp_fmul.sv =====
// Three-stage single-precision multiplier with round to nearest even.
`timescale 1ns / 1ps
module fexp_fmul import fexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    // Stage one: unpack, classify and multiply the significands.
    logic [7:0]         n_ea, n_eb;
    logic [23:0]        n_ma, n_mb;
    logic               n_a_nan, n_b_nan, n_a_inf, n_b_inf, n_a_zero, n_b_zero;
    logic signed [10:0] n_e0;

    logic [47:0]        r1_prod;
    logic signed [10:0] r1_e0;
    logic               r1_sign, r1_nan, r1_inf, r1_zero;

    always_comb begin
        n_ea     = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        n_eb     = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        n_ma     = {i_a[30:23] != 8'd0, i_a[22:0]};
        n_mb     = {i_b[30:23] != 8'd0, i_b[22:0]};
        n_a_nan  = is_nan(i_a);
        n_b_nan  = is_nan(i_b);
        n_a_inf  = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        n_b_inf  = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
        n_a_zero = (i_a[30:0] == 31'd0);
        n_b_zero = (i_b[30:0] == 31'd0);
        n_e0     = $signed({3'd0, n_ea}) + $signed({3'd0, n_eb}) - 11'sd126;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= n_ma * n_mb;
            r1_e0   <= n_e0;
            r1_sign <= i_a[31] ^ i_b[31];
            r1_nan  <= n_a_nan || n_b_nan || (n_a_inf && n_b_zero) || (n_b_inf && n_a_zero);
            r1_inf  <= n_a_inf || n_b_inf;
            r1_zero <= n_a_zero || n_b_zero;
        end
    end

    // Stage two: normalize, or shift right into the subnormal range.
    logic [5:0]         n_lz;
    logic signed [10:0] n_e0m1;
    logic signed [10:0] n_sl;
    logic [10:0]        n_rneg;
    logic [5:0]         n_rsh;
    logic [47:0]        n_q;
    logic               n_rst;
    logic signed [10:0] n_exp;

    logic [23:0]        r2_mant;
    logic               r2_g, r2_st;
    logic signed [10:0] r2_exp;
    logic               r2_sign, r2_nan, r2_inf, r2_zero;

    always_comb begin
        n_lz   = lzc48(r1_prod);
        n_e0m1 = r1_e0 - 11'sd1;
        n_rneg = 11'(-n_e0m1);
        n_rsh  = (n_rneg > 11'd63) ? 6'd63 : n_rneg[5:0];
        n_sl   = 11'sd0;
        n_rst  = 1'b0;
        if (n_e0m1 < 11'sd0) begin
            n_q   = r1_prod >> n_rsh;
            n_rst = |(r1_prod & ((48'd1 << n_rsh) - 48'd1));
        end else begin
            n_sl = ($signed({5'd0, n_lz}) < n_e0m1) ? $signed({5'd0, n_lz}) : n_e0m1;
            n_q  = r1_prod << n_sl;
        end
        n_exp = n_q[47] ? (r1_e0 - n_sl) : 11'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mant <= n_q[47:24];
            r2_g    <= n_q[23];
            r2_st   <= (|n_q[22:0]) | n_rst;
            r2_exp  <= n_exp;
            r2_sign <= r1_sign;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
            r2_zero <= r1_zero;
        end
    end

    // Stage three: round and pack, special operands take precedence.
    logic        n_inc;
    logic [30:0] n_packed;
    logic [31:0] n_res;
    logic [31:0] r3_p;

    always_comb begin
        n_inc    = r2_g && (r2_st || r2_mant[0]);
        n_packed = {r2_exp[7:0], r2_mant[22:0]} + {30'd0, n_inc};
        if (r2_nan) begin
            n_res = QNAN_CANON;
        end else if (r2_inf || (r2_exp >= 11'sd255)) begin
            n_res = {r2_sign, 8'hFF, 23'd0};
        end else if (r2_zero) begin
            n_res = {r2_sign, 31'd0};
        end else begin
            n_res = {r2_sign, n_packed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p <= n_res;
        end
    end

    assign o_p = r3_p;

endmodule

// ===== rtl/core/fexp_fadd.sv =====
// Three-stage single-precision adder with round to nearest even.
`timescale 1ns / 1ps
module fexp_fadd import fexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    // Stage one: order by magnitude and align the smaller operand.
    logic [31:0] n_big, n_sml;
    logic [7:0]  n_eb, n_es, n_d;
    logic [4:0]  n_sh;
    logic [26:0] n_mb, n_ms, n_al;
    logic        n_st, n_a_inf, n_b_inf;

    logic [26:0] r1_big, r1_sml;
    logic [7:0]  r1_e;
    logic        r1_sub, r1_sign, r1_nan, r1_inf;

    always_comb begin
        if (i_a[30:0] >= i_b[30:0]) begin
            n_big = i_a;
            n_sml = i_b;
        end else begin
            n_big = i_b;
            n_sml = i_a;
        end
        n_eb    = (n_big[30:23] == 8'd0) ? 8'd1 : n_big[30:23];
        n_es    = (n_sml[30:23] == 8'd0) ? 8'd1 : n_sml[30:23];
        n_mb    = {n_big[30:23] != 8'd0, n_big[22:0], 3'd0};
        n_ms    = {n_sml[30:23] != 8'd0, n_sml[22:0], 3'd0};
        n_d     = n_eb - n_es;
        n_sh    = (n_d > 8'd27) ? 5'd27 : n_d[4:0];
        n_al    = n_ms >> n_sh;
        n_st    = |(n_ms & ((27'd1 << n_sh) - 27'd1));
        n_a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
        n_b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_big  <= n_mb;
            r1_sml  <= {n_al[26:1], n_al[0] | n_st};
            r1_e    <= n_eb;
            r1_sub  <= i_a[31] ^ i_b[31];
            r1_sign <= n_big[31];
            r1_nan  <= is_nan(i_a) || is_nan(i_b) ||
                       (n_a_inf && n_b_inf && (i_a[31] != i_b[31]));
            r1_inf  <= n_a_inf || n_b_inf;
        end
    end

    // Stage two: add or subtract, then normalize.
    logic [27:0] n_sum;
    logic [5:0]  n_lz;
    logic [8:0]  n_em1, n_sl;
    logic [26:0] n_n;
    logic [8:0]  n_exp;
    logic        n_sign;

    logic [26:0] r2_n;
    logic [8:0]  r2_exp;
    logic        r2_sign, r2_nan, r2_inf;

    always_comb begin
        n_sum  = r1_sub ? ({1'b0, r1_big} - {1'b0, r1_sml})
                        : ({1'b0, r1_big} + {1'b0, r1_sml});
        n_lz   = lzc48({n_sum[26:0], 21'd0});
        n_em1  = {1'b0, r1_e} - 9'd1;
        n_sl   = 9'd0;
        if (n_sum[27]) begin
            n_n   = {n_sum[27:2], n_sum[1] | n_sum[0]};
            n_exp = {1'b0, r1_e} + 9'd1;
        end else begin
            n_sl  = ({3'd0, n_lz} < n_em1) ? {3'd0, n_lz} : n_em1;
            n_n   = n_sum[26:0] << n_sl;
            n_exp = n_n[26] ? ({1'b0, r1_e} - n_sl) : 9'd0;
        end
        // An exact zero from cancellation is positive.
        n_sign = (n_sum == 28'd0 && r1_sub) ? 1'b0 : r1_sign;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_n    <= n_n;
            r2_exp  <= n_exp;
            r2_sign <= n_sign;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
        end
    end

    // Stage three: round and pack.
    logic        n_inc;
    logic [30:0] n_packed;
    logic [31:0] n_res;
    logic [31:0] r3_s;

    always_comb begin
        n_inc    = r2_n[2] && (r2_n[1] || r2_n[0] || r2_n[3]);
        n_packed = {r2_exp[7:0], r2_n[25:3]} + {30'd0, n_inc};
        if (r2_nan) begin
            n_res = QNAN_CANON;
        end else if (r2_inf || (r2_exp >= 9'd255)) begin
            n_res = {r2_sign, 8'hFF, 23'd0};
        end else begin
            n_res = {r2_sign, n_packed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s <= n_res;
        end
    end

    assign o_s = r3_s;

endmodule

// ===== rtl/core/fexp_rom.sv =====
// Scale table with a registered read port.
`timescale 1ns / 1ps
module fexp_rom import fexp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [IdxW-1:0] i_addr,
    output logic [31:0]     o_data
);

    logic [31:0] r_data;

    // One registered read per cycle while i_en is high.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= EXP_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/float_exp_negative_lut2048.sv =====
// Top level of the single-precision exponential for non-positive inputs.
`timescale 1ns / 1ps
// The block takes one single-precision word x per clock and returns exp(x) as
// single-precision bits; the rate is one word per cycle while the output side
// does not stall, set by the fully pipelined multiply, add and table stages.
// Inputs below about -87.34 give +0, a NaN input comes back with its quiet bit
// set, and any other NaN is returned as 0x7FC00000. When the output word is not
// taken every stage holds, and the input is not ready, so nothing is lost or
// repeated. The last flag rides with each word.
module float_exp_negative_lut2048 import fexp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fexp_in_if.sink    i_in,
    fexp_out_if.source o_out
);

    logic              adv;
    logic [NumStg:1]   r_vld;
    logic [31:0]       r_x [1:28];
    logic [28:1]       r_last;
    logic [31:0]       r_s [9:25];
    logic [31:0]       r_u [14:16];
    logic [31:0]       r_nb;
    logic [31:0]       r_f;
    logic              r_last_out;

    logic [31:0] n1, n2, n3, t1, u0, t2, t3, p0, q0, f0;
    logic [31:0] rom_q;
    logic [31:0] n_res;
    logic        n_nan_in, n_below;

    // The whole pipe moves when the output register is empty or being taken.
    assign adv = !r_vld[NumStg] || o_out.ready;
    assign i_in.ready = adv;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NumStg-1:1], i_in.valid};
        end
    end

    // Side data delay lines.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x[1]  <= i_in.x_bits;
            r_last  <= {r_last[27:1], i_in.last_in};
            for (int i = 2; i <= 28; i++) begin
                r_x[i] <= r_x[i-1];
            end
            r_nb    <= n2;
            r_s[9]  <= rom_q + {r_nb[19:0], 12'd0};
            for (int i = 10; i <= 25; i++) begin
                r_s[i] <= r_s[i-1];
            end
            r_u[14] <= u0;
            r_u[15] <= r_u[14];
            r_u[16] <= r_u[15];
        end
    end

    // n = x*log2e rounded by the magic bias.
    fexp_fmul u_mul_log2e (.i_clk(i_clk), .i_en(adv), .i_a(r_x[1]), .i_b(LOG2E), .o_p(n1));
    fexp_fadd u_add_bias (.i_clk(i_clk), .i_en(adv), .i_a(n1), .i_b(MAGIC_BIAS), .o_s(n2));

    // Scale lookup from the low index bits.
    fexp_rom u_rom (.i_clk(i_clk), .i_en(adv), .i_addr(n2[IdxW-1:0]), .o_data(rom_q));

    // Remove the bias and reduce with the two-part ln2.
    fexp_fadd u_add_unbias (.i_clk(i_clk), .i_en(adv), .i_a(n2), .i_b(NEG_MAGIC_BIAS),
                            .o_s(n3));
    fexp_fmul u_mul_hi (.i_clk(i_clk), .i_en(adv), .i_a(n3), .i_b(NEG_LN2_HI), .o_p(t1));
    fexp_fmul u_mul_lo (.i_clk(i_clk), .i_en(adv), .i_a(n3), .i_b(NEG_LN2_LO), .o_p(u0));
    fexp_fadd u_add_x (.i_clk(i_clk), .i_en(adv), .i_a(t1), .i_b(r_x[13]), .o_s(t2));
    fexp_fadd u_add_lo (.i_clk(i_clk), .i_en(adv), .i_a(r_u[16]), .i_b(t2), .o_s(t3));

    // Polynomial step and final scaling.
    fexp_fmul u_mul_c1 (.i_clk(i_clk), .i_en(adv), .i_a(t3), .i_b(COEF_C1), .o_p(p0));
    fexp_fmul u_mul_s (.i_clk(i_clk), .i_en(adv), .i_a(p0), .i_b(r_s[22]), .o_p(q0));
    fexp_fadd u_add_s (.i_clk(i_clk), .i_en(adv), .i_a(q0), .i_b(r_s[25]), .o_s(f0));

    // Special cases on the original x, and any NaN result made canonical.
    always_comb begin
        n_nan_in = is_nan(r_x[28]);
        n_below  = r_x[28][31] && (r_x[28][30:0] > CUTOFF_MAG);
        if (n_nan_in) begin
            n_res = r_x[28] | QUIET_BIT;
        end else if (n_below) begin
            n_res = 32'd0;
        end else if (is_nan(f0)) begin
            n_res = QNAN_CANON;
        end else begin
            n_res = f0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f        <= n_res;
            r_last_out <= r_last[28];
        end
    end

    assign o_out.valid    = r_vld[NumStg];
    assign o_out.f_bits   = r_f;
    assign o_out.last_out = r_last_out;

endmodule

// ===== rtl/core/fexp_chk.sv =====
// Port checker for the exponential block, bound to the top level.
`timescale 1ns / 1ps
`include "float_exp_negative_lut2048_defines.svh"
module fexp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_f,
    input logic        i_out_last
);

    // A word that waits on the output holds.
    `FEXP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_f) && $stable(i_out_last), "Output word changed while stalled.")

    // Reset empties the pipe.
    `FEXP_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "Output valid right after reset.")

    // An empty output register never blocks the input.
    `FEXP_ASSERT(a_ready_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "Input blocked with output empty.")

    // A stalled output stalls the input.
    `FEXP_ASSERT(a_ready_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready |-> !i_in_ready, "Input taken during a stall.")

    // Every NaN that leaves the block is quiet.
    `FEXP_ASSERT(a_quiet_nan, i_clk, i_rst_n, i_out_valid && (i_out_f[30:23] == 8'hFF) && (i_out_f[22:0] != 23'd0) |-> i_out_f[22], "Signaling NaN on the output.")

endmodule

bind float_exp_negative_lut2048 fexp_chk u_fexp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_f     (o_out.f_bits),
    .i_out_last  (o_out.last_out)
);

// ===== tb/float_exp_negative_lut2048_test.sv =====
// Self-checking testbench for the negative-range single-precision exponential block.
`timescale 1ns / 1ps
module float_exp_negative_lut2048_test;
    import fexp_pkg::*;

    typedef struct packed {
        logic [31:0] x_bits;
        logic        last_in;
    } x_word_t;

    typedef struct packed {
        logic [31:0] f_bits;
        logic        last_out;
    } f_word_t;

    logic i_clk;
    logic i_rst_n;

    fexp_in_if  x_chan ();
    fexp_out_if f_chan ();

    float_exp_negative_lut2048 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (x_chan.sink),
        .o_out   (f_chan.source)
    );

    // Words still to send, and the results expected back, oldest first.
    x_word_t     x_pending [$];
    f_word_t     f_expected [$];
    logic [31:0] scale_tbl [2048];
    int          phase;
    int          mismatches;
    int          words_in;
    logic        in_stuck;
    int          hold_left;
    logic        hold_done;

    // Clock with a 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Splits a nonzero binary32 into a 24-bit significand and its unbiased exponent.
    function automatic void sp_unpack(input logic [31:0] b, output logic [23:0] m,
                                      output int e);
        if (b[30:23] == 8'd0) begin
            m = {1'b0, b[22:0]};
            e = -126;
        end else begin
            m = {1'b1, b[22:0]};
            e = int'(b[30:23]) - 127;
        end
    endfunction

    // Rounds sig * 2^k to binary32, nearest even, with gradual underflow.
    function automatic logic [31:0] sp_round(input logic s, input int k,
                                             input logic [63:0] sig);
        int          lz;
        int          be;
        int          sh;
        logic [63:0] kept;
        logic [31:0] enc;
        lz = 0;
        while (!sig[63]) begin
            sig = sig << 1;
            lz++;
        end
        be = 63 + k - lz + 127;
        if (be >= 255) return {s, 8'hFF, 23'd0};
        if (be < 1) begin
            sh = 1 - be;
            if (sh > 63) begin
                sig = 64'd1;
            end else begin
                kept = sig >> sh;
                if ((kept << sh) != sig) kept[0] = 1'b1;
                sig = kept;
            end
            be = 1;
        end
        enc = (32'(be - 1) << 23) + 32'(sig[63:40]);
        if (sig[39] && ((|sig[38:0]) || sig[40])) enc = enc + 32'd1;
        return {s, enc[30:0]};
    endfunction

    function automatic logic sp_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Binary32 multiply.
    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        a_inf;
        logic        b_inf;
        logic        a_zero;
        logic        b_zero;
        logic [23:0] ma;
        logic [23:0] mb;
        int          ea;
        int          eb;
        s      = a[31] ^ b[31];
        a_inf  = a[30:0] == 31'h7F800000;
        b_inf  = b[30:0] == 31'h7F800000;
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        if (sp_nan(a) || sp_nan(b)) return QNAN_CANON;
        if ((a_inf && b_zero) || (b_inf && a_zero)) return QNAN_CANON;
        if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
        if (a_zero || b_zero) return {s, 31'd0};
        sp_unpack(a, ma, ea);
        sp_unpack(b, mb, eb);
        return sp_round(s, ea + eb - 46, 64'(ma) * 64'(mb));
    endfunction

    // Binary32 add.
    function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] tmp;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [63:0] xs;
        logic [63:0] ys;
        logic [63:0] ysh;
        int          ea;
        int          eb;
        int          d;
        if (sp_nan(a) || sp_nan(b)) return QNAN_CANON;
        if (a[30:0] == 31'h7F800000 && b[30:0] == 31'h7F800000 && a[31] != b[31])
            return QNAN_CANON;
        if (a[30:0] == 31'h7F800000) return a;
        if (b[30:0] == 31'h7F800000) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        // Larger magnitude goes first.
        if (b[30:0] > a[30:0]) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        sp_unpack(a, ma, ea);
        sp_unpack(b, mb, eb);
        d  = ea - eb;
        xs = 64'(ma) << 38;
        ys = 64'(mb) << 38;
        if (d >= 62) begin
            ys = 64'd1;
        end else begin
            ysh = ys >> d;
            if ((ysh << d) != ys) ysh[0] = 1'b1;
            ys = ysh;
        end
        if (a[31] == b[31]) return sp_round(a[31], ea - 61, xs + ys);
        if (xs == ys) return 32'd0;
        return sp_round(a[31], ea - 61, xs - ys);
    endfunction

    // Expected exp(x) word for one input word.
    function automatic f_word_t exp_word(input x_word_t w);
        logic [31:0] x;
        logic [31:0] n;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] u;
        logic [31:0] f;
        f_word_t     r;
        x          = w.x_bits;
        r.last_out = w.last_in;
        if (sp_nan(x)) begin
            r.f_bits = x | QUIET_BIT;
            return r;
        end
        n = sp_add(sp_mul(x, LOG2E), MAGIC_BIAS);
        s = scale_tbl[n[10:0]] + (n << 12);
        n = sp_add(n, NEG_MAGIC_BIAS);
        t = sp_add(sp_mul(n, NEG_LN2_HI), x);
        u = sp_mul(n, NEG_LN2_LO);
        t = sp_add(u, t);
        f = sp_add(sp_mul(sp_mul(t, COEF_C1), s), s);
        // Everything below the cutoff, minus infinity too, flushes to +0.
        if (x[31] && x[30:0] > CUTOFF_MAG) f = 32'd0;
        if (sp_nan(f)) f = QNAN_CANON;
        r.f_bits = f;
        return r;
    endfunction

    // Random x, weighted toward the meant range and the cutoff.
    function automatic logic [31:0] pick_x();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return {1'b1, 8'($urandom_range(96, 133)), 23'($urandom)};
            6: return {1'b1, 8'h85, 23'(23'h2EAC4F + $urandom_range(0, 64) - 32)};
            7: return {1'b0, 8'($urandom_range(100, 134)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Scale table: nearest binary32 to 2^(k/2048), minus k shifted left by 12.
    initial begin
        real v;
        for (int k = 0; k < 2048; k++) begin
            v = $pow(2.0, k / 2048.0);
            scale_tbl[k] = 32'($rtoi(v * 8388608.0 + 0.5)) + 32'h3F000000
                           - (32'(k) << 12);
        end
    end

    // Input side: accept at the rising edge, predict the result.
    always @(posedge i_clk) begin
        in_stuck <= x_chan.valid && !x_chan.ready;
        if (i_rst_n && x_chan.valid && x_chan.ready) begin
            f_expected.push_back(exp_word(x_pending.pop_front()));
            words_in <= words_in + 1;
        end
    end

    // Sender: a new word or an idle cycle, unless one is still waiting.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            x_chan.valid <= 1'b0;
        end else if (!in_stuck) begin
            if (x_pending.size() != 0 &&
                !((phase == 1 || phase == 3) &&
                  $urandom_range(0, 99) < (phase == 1 ? 78 : 35))) begin
                x_chan.valid   <= 1'b1;
                x_chan.x_bits  <= x_pending[0].x_bits;
                x_chan.last_in <= x_pending[0].last_in;
            end else begin
                x_chan.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off early in the run.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            f_chan.ready <= 1'b0;
        end else if (!hold_done && words_in == 40) begin
            hold_left    <= 300;
            hold_done    <= 1'b1;
            f_chan.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            f_chan.ready <= 1'b0;
        end else begin
            f_chan.ready <= !((phase == 2 || phase == 3) &&
                              $urandom_range(0, 99) < (phase == 2 ? 78 : 35));
        end
    end

    // Result side: compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        f_word_t want;
        if (i_rst_n && f_chan.valid && f_chan.ready) begin
            if (f_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: f_bits=%h last=%b",
                             f_chan.f_bits, f_chan.last_out);
            end else begin
                want = f_expected.pop_front();
                if (want.f_bits !== f_chan.f_bits || want.last_out !== f_chan.last_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected f_bits=%h last=%b, got f_bits=%h last=%b",
                                 want.f_bits, want.last_out, f_chan.f_bits, f_chan.last_out);
                end
            end
        end
    end

    // Stimulus: directed corners, then four phases of random words, idles, stalls.
    initial begin
        logic [31:0] corners [$];
        int          guard;
        corners = '{32'h00000000, 32'h80000000, 32'hFF800000, 32'h7F800000,
                    32'h7FC00000, 32'hFFC00001, 32'h7F800001, 32'hFFBFFFFF,
                    32'hC2AEAC4F, 32'hC2AEAC50, 32'hC2AEAC4E, 32'h00000001,
                    32'h80000001, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'hBF800000,
                    32'hC2AE0000, 32'h3F800000, 32'h42B00000, 32'h42B20000,
                    32'hBA000000, 32'h807FFFFF, 32'hFFFFFFFF};
        phase      = 0;
        mismatches = 0;
        words_in   = 0;
        in_stuck   = 1'b0;
        hold_left  = 0;
        hold_done  = 1'b0;
        x_chan.valid   = 1'b0;
        x_chan.x_bits  = 32'd0;
        x_chan.last_in = 1'b0;
        f_chan.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (corners[i]) x_pending.push_back('{corners[i], 1'(i % 2)});
        for (int p = 0; p < 4; p++) begin
            phase = p;
            for (int i = 0; i < 385; i++)
                x_pending.push_back('{pick_x(), $urandom_range(0, 7) == 0});
            while (x_pending.size() != 0 || f_expected.size() != 0) @(posedge i_clk);
        end
        guard = 0;
        while (guard < 60) begin
            @(posedge i_clk);
            guard++;
        end
        if (mismatches == 0 && f_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
